/* rtl/mp2_pkg.sv */
// Shared types, constants and helpers for the 2x2 max-pool stream block.
package mp2_pkg;

  // Fixed field widths
  localparam int unsigned SAMPLE_W     = 16;
  localparam int unsigned CFG_WIDTH_W  = 7;
  localparam int unsigned CFG_CHAN_W   = 9;
  localparam int unsigned CFG_DATA_W   = 9;
  localparam int unsigned CFG_INDEX_W  = 1;

  // Default build sizes
  localparam int unsigned MAX_WIDTH_DEF    = 64;
  localparam int unsigned MAX_CHANNELS_DEF = 256;

  // Register values after reset (before clamping to the build sizes) and write-time minimums
  localparam int unsigned WIDTH_RESET = 32;
  localparam int unsigned CHAN_RESET  = 1;
  localparam int unsigned WIDTH_MIN   = 2;
  localparam int unsigned CHAN_MIN    = 1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_IMAGE_WIDTH   = 1'b0,
    REG_CHANNEL_COUNT = 1'b1
  } cfg_reg_e;

  // What one item does at its map position
  typedef struct packed {
    logic col_wr;  // even column: park sample per channel
    logic row_wr;  // even row, odd column: store pair max per half-column
    logic emit;    // odd row, odd column: window complete
    logic last;    // final window of the map
  } item_ctl_t;

  function automatic logic signed [SAMPLE_W-1:0] smax(
    input logic signed [SAMPLE_W-1:0] a,
    input logic signed [SAMPLE_W-1:0] b
  );
    smax = (a > b) ? a : b;
  endfunction

endpackage

/* rtl/mp2_ram.sv */
// Simple dual-port RAM: one write port, one read port with registered data.
module mp2_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned DW    = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/mp2_pos.sv */
// Map geometry registers and row/column/channel position tracking.
module mp2_pos #(
  parameter int unsigned MAX_WIDTH    = mp2_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_CHANNELS = mp2_pkg::MAX_CHANNELS_DEF,
  localparam int unsigned CW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
  localparam int unsigned RDEPTH = ((MAX_WIDTH / 2) * MAX_CHANNELS > 1) ?
                                   (MAX_WIDTH / 2) * MAX_CHANNELS : 2,
  localparam int unsigned RAW = $clog2(RDEPTH)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  mp2_pkg::cfg_reg_e               cfg_sel_i,
  input  logic [mp2_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            adv_i,
  output mp2_pkg::item_ctl_t              ctl_o,
  output logic [CW-1:0]                   col_addr_o,
  output logic [RAW-1:0]                  row_addr_o
);

  localparam int unsigned PW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned NW = $clog2(MAX_CHANNELS + 1);
  localparam int unsigned HW = (PW > 1) ? PW - 1 : 1;
  localparam int unsigned RST_W = (mp2_pkg::WIDTH_RESET > MAX_WIDTH) ?
                                  MAX_WIDTH : mp2_pkg::WIDTH_RESET;

  logic [WW-1:0] width_q, width_d;
  logic [NW-1:0] chans_q, chans_d;
  logic [PW-1:0] row_q, row_d;
  logic [PW-1:0] col_q, col_d;
  logic [CW-1:0] ch_q, ch_d;

  logic [mp2_pkg::CFG_WIDTH_W-1:0] wr_width;
  logic [mp2_pkg::CFG_CHAN_W-1:0]  wr_chans;
  logic [WW-1:0] even_w;
  logic          in_map;
  logic          ch_wrap, col_wrap, row_wrap;
  logic [HW-1:0] half_col;

  assign wr_width = cfg_data_i[mp2_pkg::CFG_WIDTH_W-1:0];
  assign wr_chans = cfg_data_i[mp2_pkg::CFG_CHAN_W-1:0];

  // Clamp geometry once at write time
  always_comb begin
    width_d = width_q;
    chans_d = chans_q;
    if (cfg_we_i) begin
      unique case (cfg_sel_i)
        mp2_pkg::REG_IMAGE_WIDTH: begin
          if (32'(wr_width) < mp2_pkg::WIDTH_MIN) begin
            width_d = WW'(mp2_pkg::WIDTH_MIN);
          end else if (32'(wr_width) > MAX_WIDTH) begin
            width_d = WW'(MAX_WIDTH);
          end else begin
            width_d = WW'(wr_width);
          end
        end
        mp2_pkg::REG_CHANNEL_COUNT: begin
          if (32'(wr_chans) < mp2_pkg::CHAN_MIN) begin
            chans_d = NW'(mp2_pkg::CHAN_MIN);
          end else if (32'(wr_chans) > MAX_CHANNELS) begin
            chans_d = NW'(MAX_CHANNELS);
          end else begin
            chans_d = NW'(wr_chans);
          end
        end
        default: ;
      endcase
    end
  end

  assign even_w   = {width_q[WW-1:1], 1'b0};
  assign in_map   = (WW'(row_q) < even_w) && (WW'(col_q) < even_w);
  assign ch_wrap  = (NW'(ch_q) + NW'(1)) == chans_q;
  assign col_wrap = (WW'(col_q) + WW'(1)) == width_q;
  assign row_wrap = (WW'(row_q) + WW'(1)) == width_q;

  always_comb begin
    ctl_o.col_wr = in_map && !col_q[0];
    ctl_o.row_wr = in_map && col_q[0] && !row_q[0];
    ctl_o.emit   = in_map && col_q[0] && row_q[0];
    ctl_o.last   = (WW'(row_q) == even_w - WW'(1)) &&
                   (WW'(col_q) == even_w - WW'(1)) && ch_wrap;
  end

  assign half_col   = HW'(col_q >> 1);
  assign col_addr_o = ch_q;
  assign row_addr_o = RAW'(32'(half_col) * MAX_CHANNELS + 32'(ch_q));

  // Raster advance, channel fastest; any register write restarts the map
  always_comb begin
    row_d = row_q;
    col_d = col_q;
    ch_d  = ch_q;
    if (cfg_we_i) begin
      row_d = '0;
      col_d = '0;
      ch_d  = '0;
    end else if (adv_i) begin
      if (ch_wrap) begin
        ch_d = '0;
        if (col_wrap) begin
          col_d = '0;
          row_d = row_wrap ? '0 : row_q + PW'(1);
        end else begin
          col_d = col_q + PW'(1);
        end
      end else begin
        ch_d = ch_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= WW'(RST_W);
      chans_q <= NW'(mp2_pkg::CHAN_RESET);
      row_q   <= '0;
      col_q   <= '0;
      ch_q    <= '0;
    end else begin
      width_q <= width_d;
      chans_q <= chans_d;
      row_q   <= row_d;
      col_q   <= col_d;
      ch_q    <= ch_d;
    end
  end

endmodule

/* rtl/max_pool_2x2_stream.sv */
// 2x2 stride-2 max pooling over a streamed square multi-channel feature map.
//
// Samples arrive in raster order (row, then column, channel fastest), one
// signed Q8.8 value per item on s_axis. For each channel and each 2x2 window
// starting on an even row and even column, one item leaves on m_axis holding
// the window maximum; it goes out when the window's odd-row, odd-column
// sample has been taken, and m_axis_tlast marks the final window of the map.
// With an odd width the trailing row and column are consumed without result.
// The block takes one item per clock unless m_axis back-pressure stalls it: the
// input register, the registered read of the two on-chip stores and the result
// register form a two-stage pipeline, and a window's result is registered as its last
// sample leaves stage 1. The channel store (MAX_CHANNELS entries) keeps each channel's
// even-column sample; the row store ((MAX_WIDTH/2)*MAX_CHANNELS entries)
// keeps the even-row pair maxima per half-column and channel. Neither store
// is cleared; every entry read was written earlier in the map or is forwarded.
// Geometry is set through the cfg port (index 0: image width, clamped to
// 2..MAX_WIDTH; index 1: channel count, clamped to 1..MAX_CHANNELS); any
// write restarts the map and must only be issued while the block is idle.
module max_pool_2x2_stream #(
  parameter int unsigned MAX_WIDTH    = mp2_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_CHANNELS = mp2_pkg::MAX_CHANNELS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // config write channel
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [mp2_pkg::CFG_INDEX_W-1:0]      cfg_index_i,
  input  logic [mp2_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  // input stream
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [mp2_pkg::SAMPLE_W-1:0]         s_axis_tdata,  // [15:0] sample_value
  // output stream
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [mp2_pkg::SAMPLE_W-1:0]         m_axis_tdata,  // [15:0] pooled_value
  output logic                                 m_axis_tlast   // last_of_map
);

  localparam int unsigned SW  = mp2_pkg::SAMPLE_W;
  localparam int unsigned CW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned RDEPTH = ((MAX_WIDTH / 2) * MAX_CHANNELS > 1) ?
                                   (MAX_WIDTH / 2) * MAX_CHANNELS : 2;
  localparam int unsigned RAW = $clog2(RDEPTH);

  // Config: always ready, a write restarts the map
  logic cfg_we;
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  // Position tracking for the item on the input port
  logic                in_accept;
  mp2_pkg::item_ctl_t  ctl;
  logic [CW-1:0]       col_addr;
  logic [RAW-1:0]      row_addr;

  mp2_pos #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_pos (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_sel_i  (mp2_pkg::cfg_reg_e'(cfg_index_i)),
    .cfg_data_i (cfg_data_i),
    .adv_i      (in_accept),
    .ctl_o      (ctl),
    .col_addr_o (col_addr),
    .row_addr_o (row_addr)
  );

  // Stage 1: sample, its role in the window, and the store read data
  logic                s1_valid_q, s1_valid_d;
  mp2_pkg::item_ctl_t  s1_ctl_q;
  logic signed [SW-1:0] s1_x_q;
  logic [CW-1:0]       s1_col_addr_q;
  logic [RAW-1:0]      s1_row_addr_q;
  logic                byp_q, byp_d;   // channel store write-then-read same edge
  logic signed [SW-1:0] byp_data_q;
  logic                s1_fire;

  // Result register
  logic                out_valid_q, out_valid_d;
  logic signed [SW-1:0] out_data_q;
  logic                out_last_q;
  logic                out_load;

  // Stage 1 moves on unless it holds a result and the output is still full
  assign s1_fire  = s1_valid_q &&
                    (!s1_ctl_q.emit || !out_valid_q || m_axis_tready);
  assign out_load = s1_fire && s1_ctl_q.emit;

  assign s_axis_tready = !s1_valid_q || s1_fire;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // Stores
  logic [SW-1:0]        col_rdata, row_rdata;
  logic signed [SW-1:0] col_val, pair_max, win_max;

  mp2_ram #(
    .DEPTH (MAX_CHANNELS),
    .DW    (SW)
  ) u_col_ram (
    .clk_i   (clk_i),
    .we_i    (s1_fire && s1_ctl_q.col_wr),
    .waddr_i (s1_col_addr_q),
    .wdata_i (s1_x_q),
    .re_i    (in_accept && (ctl.row_wr || ctl.emit)),
    .raddr_i (col_addr),
    .rdata_o (col_rdata)
  );

  mp2_ram #(
    .DEPTH (RDEPTH),
    .DW    (SW)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (s1_fire && s1_ctl_q.row_wr),
    .waddr_i (s1_row_addr_q),
    .wdata_i (pair_max),
    .re_i    (in_accept && ctl.emit),
    .raddr_i (row_addr),
    .rdata_o (row_rdata)
  );

  // With one channel the odd-column item reads the sample written on the
  // same edge; forward it.
  assign byp_d = s1_fire && s1_ctl_q.col_wr && (s1_col_addr_q == col_addr);

  assign col_val  = byp_q ? byp_data_q : $signed(col_rdata);
  assign pair_max = mp2_pkg::smax(col_val, s1_x_q);
  assign win_max  = mp2_pkg::smax($signed(row_rdata), pair_max);

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_ctl_q      <= ctl;
      s1_x_q        <= $signed(s_axis_tdata);
      s1_col_addr_q <= col_addr;
      s1_row_addr_q <= row_addr;
      byp_q         <= byp_d;
      byp_data_q    <= s1_x_q;
    end
    if (out_load) begin
      out_data_q <= win_max;
      out_last_q <= s1_ctl_q.last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule
